/* design/milne_predictor_corrector_step_defines.svh */
// assertion macros for the milne step block
`ifndef MILNE_PREDICTOR_CORRECTOR_STEP_DEFINES_SVH
`define MILNE_PREDICTOR_CORRECTOR_STEP_DEFINES_SVH

// check a property outside reset
`define MPCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// check a property including the reset cycles
`define MPCS_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* design/mpcs_pkg.sv */
package mpcs_pkg;

   localparam int WIN_DEPTH = 4;
   localparam int NUM_COEF  = 8;
   localparam int CSR_IDX_W = 4;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               first_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] next_x;
      logic signed [31:0] predicted_y;
      logic signed [31:0] corrected_y;
      logic signed [31:0] slope_next;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic take;
   } link_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* design/mpcs_front.sv */
module mpcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mpcs_pkg::req_type req_data,
   input  logic              take,
   output logic              valid,
   output mpcs_pkg::req_type head
);

   mpcs_pkg::req_type q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;

   assign req_full = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign head     = q_ff[rptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = take && valid;

   always_comb begin
      wptr_in  = push_ok ? !wptr_ff : wptr_ff;
      rptr_in  = pop_ok ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wptr_ff] <= req_data;
      end
   end

endmodule

/* design/mpcs_back.sv */
module mpcs_back #(
   parameter int POLY_DEGREE = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [mpcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data,
   input  mpcs_pkg::link_type              link_in,
   output logic                            link_take,
   input  mpcs_pkg::req_type               head,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output mpcs_pkg::rsp_type               rsp_data
);

   localparam logic [1:0] DEG = 2'(POLY_DEGREE);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_HMUL = 4'd1;
   localparam logic [3:0] S_HADD = 4'd2;
   localparam logic [3:0] S_UPD  = 4'd3;
   localparam logic [3:0] S_PREP = 4'd4;
   localparam logic [3:0] S_TMUL = 4'd5;
   localparam logic [3:0] S_TABS = 4'd6;
   localparam logic [3:0] S_TDIV = 4'd7;
   localparam logic [3:0] S_TFIN = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic signed [31:0] coef_ff [mpcs_pkg::NUM_COEF];

   logic [3:0]         state_ff, state_in;
   logic               pass_ff, pass_in;
   logic               poly_ff, poly_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               term_ff, term_in;
   logic               first_ff, first_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] f_ff, f_in;
   logic signed [31:0] px_ff, px_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        mag_ff, mag_in;
   logic [63:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic [3:0]         dcnt_ff, dcnt_in;
   logic [1:0]         rem_ff, rem_in;
   logic signed [31:0] h_ff, h_in;
   logic signed [31:0] nx_ff, nx_in;
   logic signed [31:0] mulop_ff, mulop_in;
   logic signed [31:0] fn_ff, fn_in;
   logic signed [31:0] yp_ff, yp_in;
   logic signed [31:0] yc_ff, yc_in;
   logic signed [31:0] wx_ff [mpcs_pkg::WIN_DEPTH];
   logic signed [31:0] wy_ff [mpcs_pkg::WIN_DEPTH];
   logic signed [31:0] wf_ff [mpcs_pkg::WIN_DEPTH];
   logic signed [31:0] wx_in [mpcs_pkg::WIN_DEPTH];
   logic signed [31:0] wy_in [mpcs_pkg::WIN_DEPTH];
   logic signed [31:0] wf_in [mpcs_pkg::WIN_DEPTH];
   logic [2:0]         held_ff, held_in;
   logic               out_valid_ff, out_valid_in;
   mpcs_pkg::rsp_type  out_data_ff, out_data_in;

   logic signed [31:0] coef_sel;
   logic signed [31:0] qprod;
   logic signed [31:0] hsum;
   logic signed [31:0] fval;
   logic [5:0]         dig;
   logic [3:0]         qd;
   logic signed [63:0] qs;
   logic signed [31:0] tsat;
   logic [2:0]         held_eff;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign link_take = (state_ff == S_IDLE) && link_in.valid;

   assign coef_sel = coef_ff[{poly_ff, cnt_ff - 2'd1}];
   assign qprod    = mpcs_pkg::sat32(prod_ff >>> 16);
   assign hsum     = mpcs_pkg::sat32(64'(coef_sel) + 64'(qprod));
   assign fval     = mpcs_pkg::sat32(64'(px_ff) + 64'(hsum));
   assign dig      = {rem_ff, mag_ff[63:60]};
   assign qs       = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign tsat     = term_ff ? mpcs_pkg::sat32(qs >>> 16) : mpcs_pkg::sat32(qs >>> 14);
   assign held_eff = first_ff ? 3'd0 : held_ff;

   always_comb begin
      qd = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (dig >= 6'(3 * k)) begin
            qd = 4'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      poly_in      = poly_ff;
      cnt_in       = cnt_ff;
      term_in      = term_ff;
      first_in     = first_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      f_in         = f_ff;
      px_in        = px_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      rem_in       = rem_ff;
      h_in         = h_ff;
      nx_in        = nx_ff;
      mulop_in     = mulop_ff;
      fn_in        = fn_ff;
      yp_in        = yp_ff;
      yc_in        = yc_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      wf_in        = wf_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (link_in.valid) begin
               x_in     = head.point_x;
               y_in     = head.point_y;
               first_in = head.first_point;
               pass_in  = 1'b0;
               poly_in  = 1'b0;
               cnt_in   = DEG;
               acc_in   = coef_ff[{1'b0, DEG}];
               state_in = S_HMUL;
            end
         end
         S_HMUL: begin
            prod_in  = (poly_ff ? y_ff : x_ff) * acc_ff;
            state_in = S_HADD;
         end
         S_HADD: begin
            cnt_in   = cnt_ff - 2'd1;
            acc_in   = hsum;
            state_in = S_HMUL;
            if (cnt_ff == 2'd1) begin
               if (!poly_ff) begin
                  px_in   = hsum;
                  poly_in = 1'b1;
                  cnt_in  = DEG;
                  acc_in  = coef_ff[{1'b1, DEG}];
               end else if (!pass_ff) begin
                  f_in     = fval;
                  state_in = S_UPD;
               end else begin
                  fn_in    = fval;
                  mulop_in = mpcs_pkg::sat32(64'(wf_ff[2]) + 4 * 64'(wf_ff[3]) + 64'(fval));
                  term_in  = 1'b1;
                  state_in = S_TMUL;
               end
            end
         end
         S_UPD: begin
            if (held_eff == 3'(mpcs_pkg::WIN_DEPTH)) begin
               for (int i = 0; i < mpcs_pkg::WIN_DEPTH - 1; i++) begin
                  wx_in[i] = wx_ff[i + 1];
                  wy_in[i] = wy_ff[i + 1];
                  wf_in[i] = wf_ff[i + 1];
               end
               wx_in[mpcs_pkg::WIN_DEPTH - 1] = x_ff;
               wy_in[mpcs_pkg::WIN_DEPTH - 1] = y_ff;
               wf_in[mpcs_pkg::WIN_DEPTH - 1] = f_ff;
               held_in  = held_eff;
               state_in = S_PREP;
            end else begin
               wx_in[held_eff[1:0]] = x_ff;
               wy_in[held_eff[1:0]] = y_ff;
               wf_in[held_eff[1:0]] = f_ff;
               held_in  = held_eff + 3'd1;
               state_in = (held_eff == 3'(mpcs_pkg::WIN_DEPTH - 1)) ? S_PREP : S_IDLE;
            end
         end
         S_PREP: begin
            h_in     = mpcs_pkg::sat32(64'(wx_ff[1]) - 64'(wx_ff[0]));
            nx_in    = mpcs_pkg::sat32(64'(wx_ff[3]) + 64'(mpcs_pkg::sat32(
                          64'(wx_ff[1]) - 64'(wx_ff[0]))));
            mulop_in = mpcs_pkg::sat32(2 * 64'(wf_ff[1]) - 64'(wf_ff[2]) + 2 * 64'(wf_ff[3]));
            term_in  = 1'b0;
            state_in = S_TMUL;
         end
         S_TMUL: begin
            prod_in  = h_ff * mulop_ff;
            state_in = S_TABS;
         end
         S_TABS: begin
            neg_in   = prod_ff[63];
            mag_in   = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
            quo_in   = 64'd0;
            rem_in   = 2'd0;
            dcnt_in  = 4'd15;
            state_in = S_TDIV;
         end
         S_TDIV: begin
            mag_in  = {mag_ff[59:0], 4'd0};
            quo_in  = {quo_ff[59:0], qd};
            rem_in  = 2'(dig - 6'(3 * qd));
            dcnt_in = dcnt_ff - 4'd1;
            if (dcnt_ff == 4'd0) begin
               state_in = S_TFIN;
            end
         end
         S_TFIN: begin
            if (!term_ff) begin
               yp_in    = mpcs_pkg::sat32(64'(wy_ff[0]) + 64'(tsat));
               x_in     = nx_ff;
               y_in     = mpcs_pkg::sat32(64'(wy_ff[0]) + 64'(tsat));
               pass_in  = 1'b1;
               poly_in  = 1'b0;
               cnt_in   = DEG;
               acc_in   = coef_ff[{1'b0, DEG}];
               state_in = S_HMUL;
            end else begin
               yc_in    = mpcs_pkg::sat32(64'(wy_ff[2]) + 64'(tsat));
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in            = 1'b1;
               out_data_in.next_x      = nx_ff;
               out_data_in.predicted_y = yp_ff;
               out_data_in.corrected_y = yc_ff;
               out_data_in.slope_next  = fn_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < mpcs_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable && (csr_index < mpcs_pkg::CSR_IDX_W'(mpcs_pkg::NUM_COEF))) begin
            coef_ff[csr_index[2:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      poly_ff     <= poly_in;
      cnt_ff      <= cnt_in;
      term_ff     <= term_in;
      first_ff    <= first_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      f_ff        <= f_in;
      px_ff       <= px_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      dcnt_ff     <= dcnt_in;
      rem_ff      <= rem_in;
      h_ff        <= h_in;
      nx_ff       <= nx_in;
      mulop_ff    <= mulop_in;
      fn_ff       <= fn_in;
      yp_ff       <= yp_in;
      yc_ff       <= yc_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      wf_ff       <= wf_in;
      out_data_ff <= out_data_in;
   end

endmodule

/* design/milne_predictor_corrector_step.sv */
// One shared 32x32 multiplier and a four-bit-per-cycle divide-by-three sequencer do
// the arithmetic of a step; a point that does not complete the window yields no result.
// A new request is taken only once the previous one is done; a two-entry request queue
// and the result register let either side stall on its own.
// Reset (synchronous, active high) empties both queues, clears the window and coefficients.
module milne_predictor_corrector_step #(
   parameter int POLY_DEGREE = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  mpcs_pkg::req_type              req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output mpcs_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [mpcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);

   mpcs_pkg::link_type link;
   mpcs_pkg::req_type  head;
   logic               head_valid;
   logic               take;

   always_comb begin
      link.valid = head_valid;
      link.take  = take;
   end

   mpcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .take     (link.take),
      .valid    (head_valid),
      .head     (head)
   );

   mpcs_back #(
      .POLY_DEGREE (POLY_DEGREE)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .link_in          (link),
      .link_take        (take),
      .head             (head),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data)
   );

endmodule

/* design/mpcs_checker.sv */
`include "milne_predictor_corrector_step_defines.svh"

module mpcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input mpcs_pkg::rsp_type rsp_data
);

   `MPCS_ASSERT_RST(a_reset_empty, clock, reset |=> rsp_empty)
   `MPCS_ASSERT_RST(a_reset_not_full, clock, reset |=> !req_full)
   `MPCS_ASSERT(a_rsp_held, clock, reset, (!rsp_empty && !rsp_pop) |=> !rsp_empty)
   `MPCS_ASSERT(a_rsp_stable, clock, reset, (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))

endmodule

bind milne_predictor_corrector_step mpcs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

/* tb/milne_step_checker.sv */
`timescale 1ns / 100ps

module milne_step_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  mpcs_pkg::req_type              req_data,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  mpcs_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [mpcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output int                             failures,
   output int                             steps_pending
);
   import mpcs_pkg::*;

   localparam int DEGREE = 3;

   logic signed [31:0] coef [NUM_COEF];
   logic signed [31:0] win_x [WIN_DEPTH];
   logic signed [31:0] win_y [WIN_DEPTH];
   logic signed [31:0] win_f [WIN_DEPTH];
   int held;
   rsp_type step_queue[$];

   function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return clamp(p >>> 16);
   endfunction

   function automatic logic signed [31:0] poly(input int base, input logic signed [31:0] v);
      logic signed [31:0] p;
      p = coef[base + DEGREE];
      for (int i = DEGREE; i >= 1; i--) p = clamp(64'(coef[base + i - 1]) + 64'(qmul(v, p)));
      return p;
   endfunction

   function automatic logic signed [31:0] slope_at(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
      return clamp(64'(poly(0, x)) + 64'(poly(4, y)));
   endfunction

   function automatic logic signed [31:0] step_term(input logic signed [31:0] h,
                                                    input logic signed [63:0] w,
                                                    input int sh);
      logic signed [63:0] p;
      p = 64'(h) * 64'(clamp(w));
      p = p / 64'sd3;
      return clamp(p >>> sh);
   endfunction

   task automatic accept_point(input req_type r);
      logic signed [31:0] f, h, nx, yp, fn, yc;
      logic signed [63:0] s, c;
      rsp_type e;
      f = slope_at(r.point_x, r.point_y);
      if (r.first_point) held = 0;
      if (held >= WIN_DEPTH) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_x[i] = win_x[i + 1];
            win_y[i] = win_y[i + 1];
            win_f[i] = win_f[i + 1];
         end
         held = WIN_DEPTH - 1;
      end
      win_x[held] = r.point_x;
      win_y[held] = r.point_y;
      win_f[held] = f;
      held++;
      if (held < WIN_DEPTH) return;
      h = clamp(64'(win_x[1]) - 64'(win_x[0]));
      nx = clamp(64'(win_x[3]) + 64'(h));
      s = 2 * 64'(win_f[1]) - 64'(win_f[2]) + 2 * 64'(win_f[3]);
      yp = clamp(64'(win_y[0]) + 64'(step_term(h, s, 14)));
      fn = slope_at(nx, yp);
      c = 64'(win_f[2]) + 4 * 64'(win_f[3]) + 64'(fn);
      yc = clamp(64'(win_y[2]) + 64'(step_term(h, c, 16)));
      e.next_x = nx;
      e.predicted_y = yp;
      e.corrected_y = yc;
      e.slope_next = fn;
      step_queue.push_back(e);
   endtask

   assign steps_pending = step_queue.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) coef[i] = '0;
         held = 0;
         failures = 0;
      end else begin
         if (csr_write_enable && csr_index < NUM_COEF) coef[csr_index] = csr_data;
         if (rsp_pop && !rsp_empty) begin
            if (step_queue.size() == 0) begin
               $error("result with none expected");
               failures++;
            end else begin
               e = step_queue.pop_front();
               if (rsp_data.next_x !== e.next_x) begin
                  $error("next_x exp %0d got %0d", e.next_x, rsp_data.next_x);
                  failures++;
               end
               if (rsp_data.predicted_y !== e.predicted_y) begin
                  $error("predicted_y exp %0d got %0d", e.predicted_y, rsp_data.predicted_y);
                  failures++;
               end
               if (rsp_data.corrected_y !== e.corrected_y) begin
                  $error("corrected_y exp %0d got %0d", e.corrected_y, rsp_data.corrected_y);
                  failures++;
               end
               if (rsp_data.slope_next !== e.slope_next) begin
                  $error("slope_next exp %0d got %0d", e.slope_next, rsp_data.slope_next);
                  failures++;
               end
            end
         end
         if (req_push && !req_full) accept_point(req_data);
      end
   end

endmodule

/* tb/milne_predictor_corrector_step_test.sv */
`timescale 1ns / 100ps

module milne_predictor_corrector_step_test;
   import mpcs_pkg::*;

   localparam int NUM_RANDOM = 730;
   localparam int SETTLE = 200;
   localparam longint CYCLE_LIMIT = 2_000_000;

   typedef enum int {
      COEF_X0, COEF_X1, COEF_X2, COEF_X3, COEF_Y0, COEF_Y1, COEF_Y2, COEF_Y3
   } csr_index_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int failures;
   int steps_pending;
   longint cycles = 0;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;

   always #2 clock = ~clock;

   milne_predictor_corrector_step u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   milne_step_checker u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .steps_pending(steps_pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // random pop with idle bursts; hold off entirely while hold_off is set
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom();
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   task automatic send_request(input logic [31:0] x, input logic [31:0] y, input bit first);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{point_x: x, point_y: y, first_point: first};
      do @(posedge clock); while (req_full);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (steps_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // small coefficients keep values in range; some phases use extremes
   task automatic load_coefs(input int style);
      for (int i = 0; i < 8; i++) begin
         case (style)
            0: write_csr(csr_index_type'(i), 32'h0);
            1: write_csr(csr_index_type'(i), (i % 2) ? 32'h7fffffff : 32'h80000000);
            default: write_csr(csr_index_type'(i),
                               32'($signed($urandom_range(0, 1 << 17)) - (1 << 16)));
         endcase
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_run(input int count);
      logic [31:0] x, h;
      x = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      h = $urandom_range(0, 1 << 14);
      send_request(x, pick_value(), 1'b1);
      for (int i = 1; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(pick_value(), pick_value(), 1'($urandom_range(0, 1)));
         end else begin
            x = x + h;
            send_request(x, 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)), 1'b0);
         end
      end
   endtask

   initial begin
      int sent;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: append without restart, extremes, zero step, full window shifting
      send_request(32'h0, 32'h0, 1'b0);
      send_request(32'h00010000, 32'h7fffffff, 1'b0);
      send_request(32'h7fffffff, 32'h80000000, 1'b0);
      send_request(32'h80000000, 32'hffffffff, 1'b0);
      send_request(32'h00020000, 32'h00010000, 1'b0);
      drain();
      load_coefs(1);
      send_request(32'h00010000, 32'h00010000, 1'b1);
      send_request(32'h00010000, 32'h7fffffff, 1'b0);
      send_request(32'h00010000, 32'h80000000, 1'b0);
      send_request(32'h00010000, 32'h0, 1'b0);
      send_request(32'h80000000, 32'h7fffffff, 1'b1);
      send_request(32'h7fffffff, 32'h80000000, 1'b0);
      send_request(32'h0, 32'h7fffffff, 1'b0);
      send_request(32'hffffffff, 32'h1, 1'b0);
      send_request(32'h12345678, 32'hedcba987, 1'b0);
      drain();
      write_csr(csr_index_type'(8), 32'hffffffff);
      load_coefs(2);

      // hold the result side so the request queue fills and stalls
      hold_off = 1'b1;
      fork
         send_run(12);
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
      join

      sent = 26;
      while (sent < NUM_RANDOM) begin
         int n;
         if (sent > NUM_RANDOM - 120) quiet = 1'b1;
         if ($urandom_range(0, 5) == 0) begin
            drain();
            load_coefs($urandom_range(0, 5) == 0 ? $urandom_range(0, 1) : 2);
         end
         n = $urandom_range(4, 20);
         send_run(n);
         sent += n;
      end
      drain();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
